/* design/dq_pkg.sv */
// dq_pkg: shared types, constants and ring arithmetic for the double-ended queue
// used by the controller, datapath, top level and checker; depends on nothing else
package dq_pkg;

	// ring size and derived widths
	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 8;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// operation codes
	localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
	localparam logic [2:0] FN_POP_FRONT  = 3'd2;
	localparam logic [2:0] FN_POP_BACK   = 3'd3;
	localparam logic [2:0] FN_LIST       = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// request and result payloads
	typedef struct packed {
		logic [2:0]        func;
		logic [DATA_W-1:0] item;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] item_out;
		logic [1:0]        status;
		logic              last_out;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
		logic list_clr;
		logic list_rd;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic empty;
		logic full;
		logic list_last;
	} stat_t;

	// ring position base + off, wrapped once at DEPTH
	function automatic idx_t ring_add(idx_t base, cnt_t off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + {1'b0, off};
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

/* design/dq_ram.sv */
// dq_ram: generic single-write, single-read ram with registered read data
// standalone, no package dependency
module dq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/dq_ctrl.sv */
// dq_ctrl: controller fsm, decodes requests, issues datapath commands, holds result strobe
// depends on dq_pkg
module dq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2:0]          func,
	input  dq_pkg::stat_t       stat,
	output dq_pkg::cmd_t        cmd,
	output logic                busy,
	output logic                strobe,
	output logic [1:0]          status,
	output logic                last_out,
	output logic                use_ram
);

	typedef enum logic {
		S_IDLE,
		S_LIST
	} state_t;

	state_t     state_q;
	logic       strobe_q;
	logic [1:0] status_q;
	logic       last_q;
	logic       use_ram_q;
	logic       accept;

	assign busy   = (state_q == S_LIST);
	assign accept = start && !busy;

	// command decode
	always_comb begin
		cmd = '0;
		if (state_q == S_LIST) begin
			cmd.list_rd = 1'b1;
		end else if (accept) begin
			case (func)
				dq_pkg::FN_PUSH_FRONT: cmd.push_front = !stat.full;
				dq_pkg::FN_PUSH_BACK:  cmd.push_back  = !stat.full;
				dq_pkg::FN_POP_FRONT:  cmd.pop_front  = !stat.empty;
				dq_pkg::FN_POP_BACK:   cmd.pop_back   = !stat.empty;
				dq_pkg::FN_LIST:       cmd.list_clr   = !stat.empty;
				default:               cmd = '0;
			endcase
		end
	end

	// state and registered result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			strobe_q  <= 1'b0;
			status_q  <= dq_pkg::ST_OK;
			last_q    <= 1'b0;
			use_ram_q <= 1'b0;
		end else begin
			strobe_q  <= 1'b0;
			use_ram_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (func) inside
							dq_pkg::FN_PUSH_FRONT, dq_pkg::FN_PUSH_BACK: begin
								strobe_q <= 1'b1;
								last_q   <= 1'b1;
								status_q <= stat.full ? dq_pkg::ST_FULL : dq_pkg::ST_OK;
							end
							dq_pkg::FN_POP_FRONT, dq_pkg::FN_POP_BACK: begin
								strobe_q  <= 1'b1;
								last_q    <= 1'b1;
								status_q  <= stat.empty ? dq_pkg::ST_EMPTY : dq_pkg::ST_OK;
								use_ram_q <= !stat.empty;
							end
							dq_pkg::FN_LIST: begin
								if (stat.empty) begin
									strobe_q <= 1'b1;
									last_q   <= 1'b1;
									status_q <= dq_pkg::ST_EMPTY;
								end else begin
									state_q <= S_LIST;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_LIST: begin
					// one entry read per cycle, front to back
					strobe_q  <= 1'b1;
					use_ram_q <= 1'b1;
					status_q  <= dq_pkg::ST_OK;
					last_q    <= stat.list_last;
					if (stat.list_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe   = strobe_q;
	assign status   = status_q;
	assign last_out = last_q;
	assign use_ram  = use_ram_q;

endmodule

/* design/dq_dp.sv */
// dq_dp: datapath with ring pointers, list counter and entry storage
// depends on dq_pkg and dq_ram
module dq_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dq_pkg::cmd_t               cmd,
	input  logic [dq_pkg::DATA_W-1:0]  item,
	input  logic                       use_ram,
	output dq_pkg::stat_t              stat,
	output logic [dq_pkg::DATA_W-1:0]  item_out
);

	dq_pkg::idx_t              front_q;
	dq_pkg::cnt_t              fill_q;
	dq_pkg::cnt_t              cnt_q;
	dq_pkg::idx_t              front_dec;
	dq_pkg::idx_t              front_inc;
	dq_pkg::idx_t              waddr;
	dq_pkg::idx_t              raddr;
	logic                      we;
	logic                      re;
	logic [dq_pkg::DATA_W-1:0] rdata;

	// wrapped neighbors of the front pointer
	assign front_dec = (front_q == '0) ? dq_pkg::idx_t'(dq_pkg::DEPTH - 1)
	                                   : front_q - dq_pkg::idx_t'(1);
	assign front_inc = (front_q == dq_pkg::idx_t'(dq_pkg::DEPTH - 1)) ? '0
	                                   : front_q + dq_pkg::idx_t'(1);

	// memory addressing
	assign we    = cmd.push_front || cmd.push_back;
	assign waddr = cmd.push_front ? front_dec : dq_pkg::ring_add(front_q, fill_q);
	assign re    = cmd.pop_front || cmd.pop_back || cmd.list_rd;

	always_comb begin
		if (cmd.pop_front) begin
			raddr = front_q;
		end else if (cmd.pop_back) begin
			raddr = dq_pkg::ring_add(front_q, fill_q - dq_pkg::cnt_t'(1));
		end else begin
			raddr = dq_pkg::ring_add(front_q, cnt_q);
		end
	end

	// pointer, fill count and list counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			fill_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.push_front) begin
				front_q <= front_dec;
			end else if (cmd.pop_front) begin
				front_q <= front_inc;
			end
			if (we) begin
				fill_q <= fill_q + dq_pkg::cnt_t'(1);
			end else if (cmd.pop_front || cmd.pop_back) begin
				fill_q <= fill_q - dq_pkg::cnt_t'(1);
			end
			if (cmd.list_clr) begin
				cnt_q <= '0;
			end else if (cmd.list_rd) begin
				cnt_q <= cnt_q + dq_pkg::cnt_t'(1);
			end
		end
	end

	dq_ram #(
		.WIDTH(dq_pkg::DATA_W),
		.DEPTH(dq_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(item),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// status toward the controller
	assign stat.empty     = (fill_q == '0);
	assign stat.full      = (fill_q == dq_pkg::cnt_t'(dq_pkg::DEPTH));
	assign stat.list_last = (cnt_q == fill_q - dq_pkg::cnt_t'(1));

	assign item_out = use_ram ? rdata : '0;

endmodule

/* design/double_ended_queue.sv */
// double_ended_queue: bounded deque of 8-bit characters on a ring buffer.
// push and pop: result in the cycle after the request, one request per cycle while not busy.
// list of n entries: results follow front to back, each after its ram read; busy is high
// while the entries are read, and the next request is taken once busy falls; paced by the single ram read port.
// reset clears front pointer, fill count and fsm; storage is not cleared.
// results are shown for one cycle with strobe; the receiver cannot stall.
module double_ended_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  dq_pkg::req_t req,
	output logic         busy,
	output logic         strobe,
	output dq_pkg::rsp_t rsp
);

	dq_pkg::cmd_t  cmd;
	dq_pkg::stat_t stat;
	logic          use_ram;
	logic [1:0]    status;
	logic          last_out;
	logic [dq_pkg::DATA_W-1:0] item_out;

	dq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.func    (req.func),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy),
		.strobe  (strobe),
		.status  (status),
		.last_out(last_out),
		.use_ram (use_ram)
	);

	dq_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.item    (req.item),
		.use_ram (use_ram),
		.stat    (stat),
		.item_out(item_out)
	);

	// result assembly
	assign rsp.item_out = item_out;
	assign rsp.status   = status;
	assign rsp.last_out = last_out;

endmodule

/* design/dq_checker.sv */
// dq_checker: port-level checks on the double-ended queue, bound to the top level
// depends on dq_pkg and double_ended_queue
module dq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         start,
	input dq_pkg::req_t req,
	input logic         busy,
	input logic         strobe,
	input dq_pkg::rsp_t rsp
);

	// push and pop requests answer with a single final result next cycle
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.func == dq_pkg::FN_PUSH_FRONT ||
		req.func == dq_pkg::FN_PUSH_BACK || req.func == dq_pkg::FN_POP_FRONT ||
		req.func == dq_pkg::FN_POP_BACK) |=> strobe && rsp.last_out)
		else $error("push or pop request without a final result");

	// empty and full results end the request and carry no character
	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rsp.status != dq_pkg::ST_OK |-> rsp.last_out && rsp.item_out == '0)
		else $error("error result not final or not zero");

	// a list stream ends with its final entry as busy drops
	a_list_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && rsp.last_out && rsp.status == dq_pkg::ST_OK)
		else $error("list ended without final entry");

	// entering a list shows no result in the first cycle
	a_list_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !strobe)
		else $error("result during list startup");

endmodule

bind double_ended_queue dq_checker u_chk (.*);
